// File: rtl/core/lrux_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrux_pkg
// Shared widths, request and status codes, and the types that travel between
// the table, the scan unit and the sequencer of the expiring LRU cache.
// ----------------------------------------------------------------------------
package lrux_pkg;

    localparam int KEY_W  = 64;
    localparam int DATA_W = 32;
    localparam int RANK_W = 5;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 3;
    localparam int SLOT_W = 4;
    localparam int CAP_W  = 5;

    localparam logic [RANK_W-1:0] RANK_MAX = 5'd31;
    localparam logic [RANK_W-1:0] RANK_NEW = 5'd1;
    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;

    localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PUT    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_HIT         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISS        = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EXPIRED     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_REMOVED     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_REMOVE_MISS = 3'd4;
    localparam logic [STAT_W-1:0] STAT_REPLACED    = 3'd5;
    localparam logic [STAT_W-1:0] STAT_FREE_SLOT   = 3'd6;
    localparam logic [STAT_W-1:0] STAT_EVICTED     = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] expiry;
    } entry_t;

    // What the scan found so far: each flag qualifies the matching index.
    typedef struct packed {
        logic match;
        logic match_stale;
        logic free;
        logic stale;
        logic lru;
        logic oldest;
    } scan_flags_t;

endpackage

// File: rtl/core/lrux_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrux_table
// Slot storage: key, value and expiry in one memory, recency ranks in another.
// Both share one registered read address; each has its own write port.
// ----------------------------------------------------------------------------
module lrux_table #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                        aclk,
    input  logic [IDX_W-1:0]            rd_addr,
    input  logic                        ent_we,
    input  logic [IDX_W-1:0]            ent_waddr,
    input  lrux_pkg::entry_t            ent_wdata,
    input  logic                        rank_we,
    input  logic [IDX_W-1:0]            rank_waddr,
    input  logic [lrux_pkg::RANK_W-1:0] rank_wdata,
    output lrux_pkg::entry_t            rd_entry,
    output logic [lrux_pkg::RANK_W-1:0] rd_rank
);
    import lrux_pkg::*;

    entry_t            ent_mem  [ENTRIES];
    logic [RANK_W-1:0] rank_mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        rd_entry <= ent_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        rd_rank <= rank_mem[rd_addr];
    end

endmodule

// File: rtl/core/lrux_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrux_scan
// Shared compare unit. It looks at one slot per cycle and keeps the first key
// match, the first free slot, the first stale slot, the last slot whose rank
// equals the capacity and the first slot of greatest rank.
// ----------------------------------------------------------------------------
module lrux_scan #(
    parameter int IDX_W = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        en,
    input  logic [IDX_W-1:0]            idx,
    input  logic                        slot_vld,
    input  lrux_pkg::entry_t            rd_entry,
    input  logic [lrux_pkg::RANK_W-1:0] rd_rank,
    input  logic [lrux_pkg::KEY_W-1:0]  key,
    input  logic [lrux_pkg::DATA_W-1:0] now_time,
    input  logic [lrux_pkg::CAP_W-1:0]  cap,
    output lrux_pkg::scan_flags_t       flags,
    output logic [IDX_W-1:0]            match_idx,
    output logic [lrux_pkg::RANK_W-1:0] match_rank,
    output logic [lrux_pkg::DATA_W-1:0] match_value,
    output logic [lrux_pkg::DATA_W-1:0] match_expiry,
    output logic [IDX_W-1:0]            free_idx,
    output logic [IDX_W-1:0]            stale_idx,
    output logic [lrux_pkg::RANK_W-1:0] stale_rank,
    output logic [IDX_W-1:0]            lru_idx,
    output logic [IDX_W-1:0]            oldest_idx,
    output logic [lrux_pkg::RANK_W-1:0] oldest_rank
);
    import lrux_pkg::*;

    scan_flags_t flags_reg, flags_next;
    logic        key_eq;
    logic        is_stale;
    logic        rank_is_cap;
    logic        rank_gt;

    assign key_eq      = (rd_entry.key == key);
    assign is_stale    = (now_time > rd_entry.expiry);
    assign rank_is_cap = (rd_rank == cap);
    assign rank_gt     = (rd_rank > oldest_rank);

    always_comb begin
        flags_next = flags_reg;
        if (clear) begin
            flags_next = '0;
        end else if (en) begin
            if (!slot_vld) begin
                flags_next.free = 1'b1;
            end else begin
                if (!flags_reg.match && key_eq) begin
                    flags_next.match       = 1'b1;
                    flags_next.match_stale = is_stale;
                end
                if (is_stale) begin
                    flags_next.stale = 1'b1;
                end
                if (rank_is_cap) begin
                    flags_next.lru = 1'b1;
                end
                flags_next.oldest = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    // Captured indices and ranks are qualified by the flags and need no reset.
    always_ff @(posedge aclk) begin
        if (en && !clear) begin
            if (!slot_vld) begin
                if (!flags_reg.free) begin
                    free_idx <= idx;
                end
            end else begin
                if (!flags_reg.match && key_eq) begin
                    match_idx    <= idx;
                    match_rank   <= rd_rank;
                    match_value  <= rd_entry.value;
                    match_expiry <= rd_entry.expiry;
                end
                if (!flags_reg.stale && is_stale) begin
                    stale_idx  <= idx;
                    stale_rank <= rd_rank;
                end
                if (rank_is_cap) begin
                    lru_idx <= idx;
                end
                if (!flags_reg.oldest || rank_gt) begin
                    oldest_idx  <= idx;
                    oldest_rank <= rd_rank;
                end
            end
        end
    end

    assign flags = flags_reg;

endmodule

// File: rtl/core/lru_cache_with_expiry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_with_expiry
// Fully associative key-value cache with exact LRU ranks and per-entry expiry.
// ----------------------------------------------------------------------------
// One request is handled at a time. After a transaction is accepted the
// sequencer scans the active slots, one per cycle through the single read port
// of the slot table, then commits the result and, when ranks change, makes a
// second pass over the same slots to age or close up their ranks. A miss, a
// missing remove or an unknown request makes no second pass. The result is
// held in an output register, so the next request is taken while it waits.
// A capacity of 0 acts as 1 and a capacity above ENTRIES acts as ENTRIES.
// ----------------------------------------------------------------------------
module lru_cache_with_expiry #(
    parameter int ENTRIES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lrux_pkg::CAP_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [lrux_pkg::REQ_W-1:0]  s_req_type,
    input  logic [lrux_pkg::KEY_W-1:0]  s_key_hash,
    input  logic [lrux_pkg::DATA_W-1:0] s_new_value,
    input  logic [lrux_pkg::DATA_W-1:0] s_new_expiry,
    input  logic [lrux_pkg::DATA_W-1:0] s_now_time,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lrux_pkg::STAT_W-1:0] m_status,
    output logic [lrux_pkg::DATA_W-1:0] m_hit_value,
    output logic [lrux_pkg::DATA_W-1:0] m_hit_expiry,
    output logic [lrux_pkg::SLOT_W-1:0] m_slot_used,
    output logic                        m_evicted_stale
);
    import lrux_pkg::*;

    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = (IDX_W > CAP_W) ? IDX_W : CAP_W;
    localparam int CAP_LIM = (ENTRIES < 31) ? ENTRIES : 31;
    localparam int BND_W   = RANK_W + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_UPDATE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   cap_eff;
    logic [CNT_W-1:0]   cnt_reg;
    logic               pend_reg;
    logic [IDX_W-1:0]   idx_d_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [REQ_W-1:0]   req_reg;
    entry_t             in_entry_reg;
    logic [DATA_W-1:0]  now_reg;

    logic               dec_mode_reg;
    logic [BND_W-1:0]   bound_reg;
    logic [IDX_W-1:0]   skip_reg;

    logic               accept;
    logic               issue;
    logic               pass_done;
    logic               go;

    entry_t             rd_entry;
    logic [RANK_W-1:0]  rd_rank;

    scan_flags_t        flags;
    logic [IDX_W-1:0]   match_idx, free_idx, stale_idx, lru_idx, oldest_idx;
    logic [RANK_W-1:0]  match_rank, stale_rank, oldest_rank;
    logic [DATA_W-1:0]  match_value, match_expiry;

    // Decision of one request.
    logic               d_set, d_clr, d_store, d_rank1, d_update, d_dec;
    logic [IDX_W-1:0]   d_idx;
    logic [BND_W-1:0]   d_bound;
    logic [STAT_W-1:0]  d_status;
    logic [DATA_W-1:0]  d_value, d_expiry;
    logic               d_stale;
    logic [SLOT_W+IDX_W-1:0] d_slot_ext;

    logic               upd_vld;
    logic [BND_W-1:0]   upd_rank_ext;
    logic               age_hit, close_hit, upd_we;
    logic [RANK_W-1:0]  upd_rank;

    logic               rank_we;
    logic [IDX_W-1:0]   rank_waddr;
    logic [RANK_W-1:0]  rank_wdata;

    assign cap_eff = (cap_reg == '0)                 ? CAP_W'(1) :
                     (cap_reg > CAP_W'(CAP_LIM))     ? CAP_W'(CAP_LIM) : cap_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign issue     = (state_reg inside {S_SCAN, S_UPDATE})
                       && (cnt_reg < CNT_W'(cap_eff));
    assign pass_done = !issue && !pend_reg;
    assign go        = (state_reg == S_DECIDE) && (!m_valid || m_ready);

    lrux_table #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .aclk       (aclk),
        .rd_addr    (cnt_reg[IDX_W-1:0]),
        .ent_we     (go && d_store),
        .ent_waddr  (d_idx),
        .ent_wdata  (in_entry_reg),
        .rank_we    (rank_we),
        .rank_waddr (rank_waddr),
        .rank_wdata (rank_wdata),
        .rd_entry   (rd_entry),
        .rd_rank    (rd_rank)
    );

    lrux_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .clear        (accept),
        .en           ((state_reg == S_SCAN) && pend_reg),
        .idx          (idx_d_reg),
        .slot_vld     (valid_reg[idx_d_reg]),
        .rd_entry     (rd_entry),
        .rd_rank      (rd_rank),
        .key          (in_entry_reg.key),
        .now_time     (now_reg),
        .cap          (cap_eff),
        .flags        (flags),
        .match_idx    (match_idx),
        .match_rank   (match_rank),
        .match_value  (match_value),
        .match_expiry (match_expiry),
        .free_idx     (free_idx),
        .stale_idx    (stale_idx),
        .stale_rank   (stale_rank),
        .lru_idx      (lru_idx),
        .oldest_idx   (oldest_idx),
        .oldest_rank  (oldest_rank)
    );

    always_comb begin
        d_set    = 1'b0;
        d_clr    = 1'b0;
        d_store  = 1'b0;
        d_rank1  = 1'b0;
        d_update = 1'b0;
        d_dec    = 1'b0;
        d_idx    = match_idx;
        d_bound  = {1'b0, match_rank};
        d_status = STAT_MISS;
        d_value  = '0;
        d_expiry = '0;
        d_stale  = 1'b0;
        case (req_reg)
            REQ_GET: begin
                if (flags.match) begin
                    d_update = 1'b1;
                    if (flags.match_stale) begin
                        d_clr    = 1'b1;
                        d_dec    = 1'b1;
                        d_status = STAT_EXPIRED;
                    end else begin
                        d_rank1  = 1'b1;
                        d_status = STAT_HIT;
                        d_value  = match_value;
                        d_expiry = match_expiry;
                    end
                end
            end
            REQ_REMOVE: begin
                if (flags.match) begin
                    d_update = 1'b1;
                    d_clr    = 1'b1;
                    d_dec    = 1'b1;
                    d_status = STAT_REMOVED;
                end else begin
                    d_status = STAT_REMOVE_MISS;
                end
            end
            REQ_PUT: begin
                d_update = 1'b1;
                d_store  = 1'b1;
                d_rank1  = 1'b1;
                d_set    = 1'b1;
                if (flags.match) begin
                    d_status = STAT_REPLACED;
                end else if (flags.free) begin
                    // A new entry in a free slot ages every other entry.
                    d_idx    = free_idx;
                    d_bound  = {1'b1, {RANK_W{1'b0}}};
                    d_status = STAT_FREE_SLOT;
                end else begin
                    d_status = STAT_EVICTED;
                    if (flags.stale) begin
                        d_idx   = stale_idx;
                        d_bound = {1'b0, stale_rank};
                        d_stale = 1'b1;
                    end else if (flags.lru) begin
                        d_idx   = lru_idx;
                        d_bound = {1'b0, cap_eff};
                    end else begin
                        d_idx   = oldest_idx;
                        d_bound = {1'b0, oldest_rank};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign d_slot_ext = {{SLOT_W{1'b0}}, d_idx};

    // Rank pass: valid bits already reflect the committed store or removal.
    assign upd_vld      = valid_reg[idx_d_reg];
    assign upd_rank_ext = {1'b0, rd_rank};
    assign age_hit      = upd_vld && (idx_d_reg != skip_reg) && (upd_rank_ext < bound_reg)
                          && (rd_rank != RANK_MAX);
    assign close_hit    = upd_vld && (upd_rank_ext > bound_reg);
    assign upd_we       = (state_reg == S_UPDATE) && pend_reg
                          && (dec_mode_reg ? close_hit : age_hit);
    assign upd_rank     = dec_mode_reg ? (rd_rank - RANK_W'(1)) : (rd_rank + RANK_W'(1));

    assign rank_we    = (go && d_rank1) || upd_we;
    assign rank_waddr = upd_we ? idx_d_reg : d_idx;
    assign rank_wdata = upd_we ? upd_rank : RANK_NEW;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (pass_done) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (go) begin
                    state_next = d_update ? S_UPDATE : S_IDLE;
                end
            end
            S_UPDATE: begin
                if (pass_done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cap_reg   <= CAP_RESET;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            pend_reg  <= issue;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (accept || go) begin
                cnt_reg <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (go && d_set) begin
                valid_reg[d_idx] <= 1'b1;
            end else if (go && d_clr) begin
                valid_reg[d_idx] <= 1'b0;
            end
            if (go) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_d_reg <= cnt_reg[IDX_W-1:0];
        if (accept) begin
            req_reg             <= s_req_type;
            in_entry_reg.key    <= s_key_hash;
            in_entry_reg.value  <= s_new_value;
            in_entry_reg.expiry <= s_new_expiry;
            now_reg             <= s_now_time;
        end
        if (go) begin
            dec_mode_reg    <= d_dec;
            bound_reg       <= d_bound;
            skip_reg        <= d_idx;
            m_status        <= d_status;
            m_hit_value     <= d_value;
            m_hit_expiry    <= d_expiry;
            m_slot_used     <= (d_status inside {STAT_MISS, STAT_REMOVE_MISS})
                               ? '0 : d_slot_ext[SLOT_W-1:0];
            m_evicted_stale <= d_stale;
        end
    end

endmodule
